// File: design/ray_unit_cube_intersect_macros.svh
// ---------------------------------------------------------------------------
// ray_unit_cube_intersect_macros
// Assertion macros for the ray/unit-cube block.
// ---------------------------------------------------------------------------
`ifndef RAY_UNIT_CUBE_INTERSECT_MACROS_SVH
`define RAY_UNIT_CUBE_INTERSECT_MACROS_SVH
// implication checked at every clock edge outside reset
`define RUCI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: lbl failed");
// next-cycle implication
`define RUCI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: lbl failed");
`endif

// File: design/ruci_pkg.sv
// ---------------------------------------------------------------------------
// ruci_pkg
// Shared types and constants for the ray/unit-cube intersection block.
// ---------------------------------------------------------------------------
package ruci_pkg;
   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int DIST_WIDTH      = 32;
   localparam int FACE_WIDTH      = 3;
   localparam int NUM_FACES       = 6;

   typedef enum logic [FACE_WIDTH-1:0] {
      FACE_POS_Y = 3'd0,
      FACE_NEG_Y = 3'd1,
      FACE_POS_Z = 3'd2,
      FACE_NEG_Z = 3'd3,
      FACE_POS_X = 3'd4,
      FACE_NEG_X = 3'd5
   } face_type;

   // axis owning each face: 0 x, 1 y, 2 z
   function automatic logic [1:0] face_axis(input logic [FACE_WIDTH-1:0] f);
      logic [1:0] a;
      a = 2'd0;
      case (f)
         FACE_POS_Y, FACE_NEG_Y: a = 2'd1;
         FACE_POS_Z, FACE_NEG_Z: a = 2'd2;
         default:                a = 2'd0;
      endcase
      return a;
   endfunction
endpackage

// File: design/ruci_stream_if.sv
// ---------------------------------------------------------------------------
// ruci_stream_if
// Valid/ready channel carrying a generic payload.
// ---------------------------------------------------------------------------
interface ruci_stream_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/ruci_divider.sv
// ---------------------------------------------------------------------------
// ruci_divider
// Pipelined signed restoring divider, one quotient bit per stage, with
// sideband carried alongside. Quotient truncates toward zero.
// ---------------------------------------------------------------------------
module ruci_divider #(
   parameter int NUM_WIDTH = 48,
   parameter int DEN_WIDTH = 24,
   parameter int SB_WIDTH  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic signed [NUM_WIDTH-1:0] in_num,
   input  logic signed [DEN_WIDTH-1:0] in_den,
   input  logic [SB_WIDTH-1:0]         in_sb,
   output logic                        out_valid,
   output logic signed [NUM_WIDTH:0]   out_quo,
   output logic [SB_WIDTH-1:0]         out_sb
);
   localparam int NS = NUM_WIDTH;
   localparam int RW = DEN_WIDTH + 1;

   logic [NS:0]          vld_ff;
   logic [NUM_WIDTH-1:0] q_ff   [NS+1];
   logic [RW-1:0]        r_ff   [NS+1];
   logic [DEN_WIDTH-1:0] d_ff   [NS+1];
   logic                 neg_ff [NS+1];
   logic [SB_WIDTH-1:0]  sb_ff  [NS+1];

   logic [NUM_WIDTH-1:0] an_in;
   logic [DEN_WIDTH-1:0] ad_in;

   always_comb begin
      an_in = in_num[NUM_WIDTH-1] ? NUM_WIDTH'(-in_num) : NUM_WIDTH'(in_num);
      ad_in = in_den[DEN_WIDTH-1] ? DEN_WIDTH'(-in_den) : DEN_WIDTH'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff[0]   <= an_in;
         r_ff[0]   <= '0;
         d_ff[0]   <= ad_in;
         neg_ff[0] <= in_num[NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1];
         sb_ff[0]  <= in_sb;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [RW:0]          sh_in;
      logic [RW:0]          df_in;
      always_comb begin
         sh_in = {r_ff[s], q_ff[s][NUM_WIDTH-1]};
         df_in = sh_in - {2'b00, d_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!df_in[RW]) begin
               r_ff[s+1] <= df_in[RW-1:0];
               q_ff[s+1] <= {q_ff[s][NUM_WIDTH-2:0], 1'b1};
            end else begin
               r_ff[s+1] <= sh_in[RW-1:0];
               q_ff[s+1] <= {q_ff[s][NUM_WIDTH-2:0], 1'b0};
            end
            d_ff[s+1]   <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            sb_ff[s+1]  <= sb_ff[s];
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[NS];
      out_quo   = neg_ff[NS] ? -$signed({1'b0, q_ff[NS]}) : $signed({1'b0, q_ff[NS]});
      out_sb    = sb_ff[NS];
   end
endmodule

// File: design/ruci_face_test.sv
// ---------------------------------------------------------------------------
// ruci_face_test
// Two-stage exact inclusive hit test for one face.
// ---------------------------------------------------------------------------
module ruci_face_test #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 16,
   parameter int FACE        = 0
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic signed [COORD_WIDTH-1:0] eye [3],
   input  logic signed [COORD_WIDTH-1:0] dir [3],
   output logic                          hit,
   output logic signed [COORD_WIDTH+1:0] num,
   output logic signed [COORD_WIDTH-1:0] den
);
   localparam int A  = (FACE < 2) ? 1 : (FACE < 4) ? 2 : 0;
   localparam int O1 = (FACE < 4) ? 0 : 1;
   localparam int O2 = (FACE < 2) ? 2 : (FACE < 4) ? 1 : 2;
   localparam int NW = COORD_WIDTH + 2;
   localparam int PW = 2 * NW + 2;
   localparam logic signed [NW-1:0] HALF = NW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [NW-1:0] P = (FACE % 2 == 1) ? -HALF : HALF;

   logic signed [NW-1:0] num_in;
   logic signed [PW-1:0] a1_ff, b1_ff, a2_ff, b2_ff, r_ff;
   logic signed [NW-1:0] num1_ff, num2_ff;
   logic signed [COORD_WIDTH-1:0] d1_ff, d2_ff;
   logic                 ok_ff, nz1_ff, nz2_ff;
   logic signed [PW-1:0] s1, s2;

   always_comb begin
      num_in = P - NW'(eye[A]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff   <= PW'(eye[O1]) * PW'(dir[A]);
         b1_ff   <= PW'(num_in) * PW'(dir[O1]);
         a2_ff   <= PW'(eye[O2]) * PW'(dir[A]);
         b2_ff   <= PW'(num_in) * PW'(dir[O2]);
         r_ff    <= PW'(HALF) * (dir[A][COORD_WIDTH-1] ? -PW'(dir[A]) : PW'(dir[A]));
         num1_ff <= num_in;
         d1_ff   <= dir[A];
         nz1_ff  <= (dir[A] != '0);
         // stage 2
         num2_ff <= num1_ff;
         d2_ff   <= d1_ff;
         nz2_ff  <= nz1_ff;
         ok_ff   <= nz1_ff && (s1 >= -r_ff) && (s1 <= r_ff)
                    && (s2 >= -r_ff) && (s2 <= r_ff);
      end
   end

   always_comb begin
      s1  = a1_ff + b1_ff;
      s2  = a2_ff + b2_ff;
      hit = ok_ff && nz2_ff;
      num = num2_ff;
      den = d2_ff;
   end
endmodule

// File: design/ray_unit_cube_intersect.sv
// ---------------------------------------------------------------------------
// ray_unit_cube_intersect
// Ray against the unit cube centred at the origin, one result per face hit.
// ---------------------------------------------------------------------------
// Usage:
//  req channel: one ray (eye, dir, signed Q7.16) per transfer.
//  rsp channel: hit, distance (Q15.16, saturated), face, last; one transfer
//   per face hit in order +y,-y,+z,-z,+x,-x, or one no-hit marker (last=1).
//  Pipeline: 2 hit-test stages (products, then compares), then all six
//   faces' t computed in parallel by six dividers of one quotient bit per
//   stage (COORD_WIDTH+FRAC_BITS+2 stages), then a result buffer.
//  Throughput: one ray per cycle into the pipeline while it is not stalled;
//   the result channel gives one result a cycle while rsp.ready is high,
//   and a ray with several results holds the pipeline until its last is taken.
//  Stall: the whole pipeline freezes while the output buffer holds a ray
//   whose results are not all taken; nothing is lost or repeated.
//  Reset: synchronous, clears all valid bits; no clearing pass.
// ---------------------------------------------------------------------------
`include "ray_unit_cube_intersect_macros.svh"
module ray_unit_cube_intersect #(
   parameter int COORD_WIDTH = ruci_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ruci_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   ruci_stream_if.sink   req,
   ruci_stream_if.source rsp
);
   localparam int NW = COORD_WIDTH + 2;
   localparam int QN = NW + FRAC_BITS;
   localparam int DW = ruci_pkg::DIST_WIDTH;
   localparam int NF = ruci_pkg::NUM_FACES;
   // signed 32-bit limits, one bit wider so they compare as signed values
   localparam logic signed [DW:0] T_MAX = {2'b00, {(DW-1){1'b1}}};
   localparam logic signed [DW:0] T_MIN = {2'b11, {(DW-1){1'b0}}};

   // req.data layout: {dir_z,dir_y,dir_x,eye_z,eye_y,eye_x}, eye_x at LSB
   // rsp.data layout: {last, face, distance, hit}, hit at LSB
   logic signed [COORD_WIDTH-1:0] eye [3];
   logic signed [COORD_WIDTH-1:0] dir [3];
   logic        adv;
   logic        v1_ff, v2_ff;

   // output buffer: one ray's results
   logic          obuf_vld_ff;
   logic [NF-1:0] obuf_hit_ff;
   logic signed [DW-1:0] obuf_t_ff [NF];
   logic [NF-1:0] pend_ff;
   logic [ruci_pkg::FACE_WIDTH-1:0] cur_face;
   logic          cur_last;
   logic          out_stall;

   logic [NF-1:0] fhit;
   logic signed [NW-1:0] fnum [NF];
   logic signed [COORD_WIDTH-1:0] fden [NF];
   logic [NF-1:0] dvalid;
   logic signed [QN:0] dquo [NF];
   logic [NF-1:0] dhit;
   logic [NF-1:0] dsb [NF];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye[i] = req.data[i*COORD_WIDTH +: COORD_WIDTH];
         dir[i] = req.data[(i+3)*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   logic done_take;
   assign done_take = rsp.valid && rsp.ready && cur_last;
   assign adv = !obuf_vld_ff || done_take;
   assign req.ready = adv;
   assign out_stall = rsp.valid && !rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
   end

   for (genvar f = 0; f < NF; f++) begin : g_face
      ruci_face_test #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .FACE(f)) u_test (
         .clock(clock), .adv(adv), .eye(eye), .dir(dir),
         .hit(fhit[f]), .num(fnum[f]), .den(fden[f]));
      ruci_divider #(.NUM_WIDTH(QN), .DEN_WIDTH(COORD_WIDTH), .SB_WIDTH(NF)) u_div (
         .clock(clock), .reset(reset), .adv(adv), .in_valid(v2_ff),
         .in_num({fnum[f], FRAC_BITS'(0)}),
         .in_den(fhit[f] ? fden[f] : COORD_WIDTH'(1)),
         .in_sb(fhit),
         .out_valid(dvalid[f]), .out_quo(dquo[f]), .out_sb(dsb[f]));
      assign dhit[f] = dsb[0][f];
   end

   function automatic logic signed [DW-1:0] sat(input logic signed [QN:0] q);
      logic signed [DW-1:0] r;
      if (q > T_MAX) r = T_MAX[DW-1:0];
      else if (q < T_MIN) r = T_MIN[DW-1:0];
      else r = DW'(q);
      return r;
   endfunction

   // pick lowest pending face
   always_comb begin
      cur_face = '0;
      for (int i = NF - 1; i >= 0; i--) begin
         if (pend_ff[i]) cur_face = ruci_pkg::FACE_WIDTH'(i);
      end
      cur_last = ($countones(pend_ff) <= 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_vld_ff <= 1'b0;
         pend_ff     <= '0;
      end else if (adv) begin
         obuf_vld_ff <= dvalid[0];
         pend_ff     <= dhit;
      end else if (rsp.valid && rsp.ready) begin
         pend_ff[cur_face] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         obuf_hit_ff <= dhit;
         for (int i = 0; i < NF; i++) obuf_t_ff[i] <= sat(dquo[i]);
      end
   end

   assign rsp.valid = obuf_vld_ff;
   assign rsp.data  = {cur_last, cur_face,
                       (pend_ff != '0) ? obuf_t_ff[cur_face] : DW'(0),
                       (pend_ff != '0)};

   `RUCI_ASSERT_IMPL(a_last_one_pending, clock, reset, rsp.valid && cur_last, $countones(pend_ff) <= 1)
   `RUCI_ASSERT_NEXT(a_hold_stall, clock, reset, out_stall, rsp.valid && $stable(pend_ff))
   `RUCI_ASSERT_IMPL(a_pend_subset, clock, reset, rsp.valid, (pend_ff & ~obuf_hit_ff) == '0)
endmodule
